// ----- rtl/bsc_pkg.sv -----
// Shared types and constants for the barometric sensor compensation block.
`default_nettype none

package bsc_pkg;

  // Register stages from input register to output register.
  localparam int unsigned NUM_STAGES = 11;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS_COEFF       = 4'd0,
    REG_OFFSET_COEFF     = 4'd1,
    REG_SENS_TEMPCO      = 4'd2,
    REG_OFFSET_TEMPCO    = 4'd3,
    REG_REF_TEMP_COEFF   = 4'd4,
    REG_TEMP_SLOPE_COEFF = 4'd5,
    REG_MIN_PRESSURE     = 4'd6,
    REG_MAX_PRESSURE     = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
    logic [17:0] p_min;
    logic [17:0] p_max;
  } cfg_t;

  localparam logic [17:0] P_MIN_RESET = 18'd1000;
  localparam logic [17:0] P_MAX_RESET = 18'd120000;

  // Valid temperature window, hundredths of a degree.
  localparam logic signed [19:0] TEMP_MIN = -20'sd4000;
  localparam logic signed [19:0] TEMP_MAX = 20'sd8500;

endpackage

`default_nettype wire

// ----- rtl/bsc_datapath.sv -----
// Compensation datapath: eleven register stages, each loaded by its own enable.
`default_nettype none

module bsc_datapath (
  input  logic                             clk_i,
  input  logic [bsc_pkg::NUM_STAGES-1:0]   en_i,
  input  bsc_pkg::cfg_t                    cfg_i,
  input  logic [23:0]                      raw_pressure_i,
  input  logic [23:0]                      raw_temperature_i,
  output logic                             valid_res_o,
  output logic signed [14:0]               temperature_centi_c_o,
  output logic [17:0]                      pressure_pa_o
);

  // Side registers carried along the pipe
  logic              zero_q [0:9];
  logic [23:0]       d1_q   [0:5];
  logic signed [19:0] temp_q [4:9];

  // stage 0: dt
  logic signed [24:0] s0_dt_d, s0_dt_q;

  // stage 1: products on dt
  logic signed [16:0] c3_s, c4_s, c6_s;
  logic signed [41:0] s1_mt_d, s1_mt_q;
  logic signed [41:0] s1_moff_d, s1_moff_q;
  logic signed [41:0] s1_msens_d, s1_msens_q;
  logic signed [49:0] s1_mdd_d, s1_mdd_q;

  // stage 2: first-order temp, off, sens
  logic signed [41:0] mt_b, mt_sh, moff_b, moff_sh, msens_b, msens_sh;
  logic signed [19:0] s2_temp1_d, s2_temp1_q;
  logic signed [43:0] s2_off1_d, s2_off1_q;
  logic signed [39:0] s2_sens1_d, s2_sens1_q;
  logic [17:0]        s2_t2_d, s2_t2_q;

  // stage 3: squares of the temperature deviations
  logic signed [19:0] dev, dv;
  logic signed [39:0] s3_low_d, s3_low_q, s3_vlow_d, s3_vlow_q;
  logic               s3_lt_d, s3_lt_q, s3_vlt_d, s3_vlt_q;
  logic signed [19:0] s3_temp1_q;
  logic [17:0]        s3_t2_q;
  logic signed [43:0] s3_off1_q;
  logic signed [39:0] s3_sens1_q;

  // stage 4: second-order terms, gated
  logic signed [43:0] low44, vl44, off2a_full;
  logic signed [43:0] s4_off2a_d, s4_off2a_q, s4_off2b_d, s4_off2b_q;
  logic signed [39:0] s4_sens2a_d, s4_sens2a_q, s4_sens2b_d, s4_sens2b_q;
  logic signed [19:0] s4_temp_d;
  logic signed [43:0] s4_off1_q;
  logic signed [39:0] s4_sens1_q;

  // stage 5: final off and sens
  logic signed [43:0] s5_off_d, s5_off_q;
  logic signed [39:0] s5_sens_d, s5_sens_q;

  // stage 6: d1 * sens as two partial products
  logic [19:0]        sens_lo;
  logic signed [19:0] sens_hi;
  logic signed [24:0] d1_s;
  logic [43:0]        s6_plo_d, s6_plo_q;
  logic signed [43:0] s6_phi_d, s6_phi_q;
  logic signed [43:0] s6_off_q;

  // stage 7..9
  logic signed [63:0] s7_prod_d, s7_prod_q, prod_b, prod_sh;
  logic signed [43:0] s7_off_q, s8_off_q;
  logic signed [42:0] s8_q1_d, s8_q1_q;
  logic signed [44:0] s9_diff_d, s9_diff_q, diff_b, diff_sh;

  // stage 10: pressure and checks
  logic signed [29:0] pres;
  logic               res_ok;

  assign s0_dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cfg_i.c5, 8'h00});

  assign c3_s = $signed({1'b0, cfg_i.c3});
  assign c4_s = $signed({1'b0, cfg_i.c4});
  assign c6_s = $signed({1'b0, cfg_i.c6});
  assign s1_mt_d    = s0_dt_q * c6_s;
  assign s1_moff_d  = s0_dt_q * c4_s;
  assign s1_msens_d = s0_dt_q * c3_s;
  assign s1_mdd_d   = s0_dt_q * s0_dt_q;

  // signed shifts with bias give truncation toward zero
  assign mt_b     = s1_mt_q + (s1_mt_q[41] ? 42'sd8388607 : 42'sd0);
  assign mt_sh    = mt_b >>> 23;
  assign moff_b   = s1_moff_q + (s1_moff_q[41] ? 42'sd63 : 42'sd0);
  assign moff_sh  = moff_b >>> 6;
  assign msens_b  = s1_msens_q + (s1_msens_q[41] ? 42'sd127 : 42'sd0);
  assign msens_sh = msens_b >>> 7;

  assign s2_temp1_d = 20'(mt_sh) + 20'sd2000;
  assign s2_off1_d  = $signed({11'b0, cfg_i.c2, 17'b0}) + 44'(moff_sh);
  assign s2_sens1_d = $signed({8'b0, cfg_i.c1, 16'b0}) + 40'(msens_sh);
  assign s2_t2_d    = s1_mdd_q[48:31];  // dt*dt is never negative

  assign dev       = s2_temp1_q - 20'sd2000;
  assign dv        = s2_temp1_q + 20'sd1500;
  assign s3_low_d  = dev * dev;
  assign s3_vlow_d = dv * dv;
  assign s3_lt_d   = s2_temp1_q < 20'sd2000;
  assign s3_vlt_d  = s2_temp1_q < -20'sd1500;

  assign low44      = 44'(s3_low_q);
  assign vl44       = 44'(s3_vlow_q);
  assign off2a_full = (low44 <<< 6) - (low44 <<< 1) - low44;
  assign s4_off2a_d  = s3_lt_q  ? (off2a_full >>> 4) : 44'sd0;
  assign s4_off2b_d  = s3_vlt_q ? ((vl44 <<< 4) - vl44) : 44'sd0;
  assign s4_sens2a_d = s3_lt_q  ? (s3_low_q <<< 1) : 40'sd0;
  assign s4_sens2b_d = s3_vlt_q ? (s3_vlow_q <<< 3) : 40'sd0;
  assign s4_temp_d   = s3_lt_q ? (s3_temp1_q - $signed({2'b0, s3_t2_q})) : s3_temp1_q;

  assign s5_off_d  = s4_off1_q - s4_off2a_q - s4_off2b_q;
  assign s5_sens_d = s4_sens1_q - s4_sens2a_q - s4_sens2b_q;

  assign sens_lo  = s5_sens_q[19:0];
  assign sens_hi  = s5_sens_q[39:20];
  assign d1_s     = $signed({1'b0, d1_q[5]});
  assign s6_plo_d = d1_q[5] * sens_lo;
  assign s6_phi_d = d1_s * sens_hi;

  assign s7_prod_d = $signed({s6_phi_q, 20'h00000}) + $signed({20'h00000, s6_plo_q});

  assign prod_b  = s7_prod_q + (s7_prod_q[63] ? 64'sd2097151 : 64'sd0);
  assign prod_sh = prod_b >>> 21;
  assign s8_q1_d = 43'(prod_sh);

  assign s9_diff_d = s8_q1_q - s8_off_q;

  assign diff_b  = s9_diff_q + (s9_diff_q[44] ? 45'sd32767 : 45'sd0);
  assign diff_sh = diff_b >>> 15;
  assign pres    = 30'(diff_sh);
  assign res_ok  = !zero_q[9]
                && (temp_q[9] >= bsc_pkg::TEMP_MIN) && (temp_q[9] <= bsc_pkg::TEMP_MAX)
                && (pres >= $signed({12'b0, cfg_i.p_min}))
                && (pres <= $signed({12'b0, cfg_i.p_max}));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zero_q[0] <= (raw_pressure_i == 24'd0) || (raw_temperature_i == 24'd0);
      d1_q[0]   <= raw_pressure_i;
      s0_dt_q   <= s0_dt_d;
    end
    for (int k = 1; k < 10; k++) begin
      if (en_i[k]) zero_q[k] <= zero_q[k-1];
    end
    for (int k = 1; k < 6; k++) begin
      if (en_i[k]) d1_q[k] <= d1_q[k-1];
    end
    for (int k = 5; k < 10; k++) begin
      if (en_i[k]) temp_q[k] <= temp_q[k-1];
    end
    if (en_i[1]) begin
      s1_mt_q    <= s1_mt_d;
      s1_moff_q  <= s1_moff_d;
      s1_msens_q <= s1_msens_d;
      s1_mdd_q   <= s1_mdd_d;
    end
    if (en_i[2]) begin
      s2_temp1_q <= s2_temp1_d;
      s2_off1_q  <= s2_off1_d;
      s2_sens1_q <= s2_sens1_d;
      s2_t2_q    <= s2_t2_d;
    end
    if (en_i[3]) begin
      s3_low_q   <= s3_low_d;
      s3_vlow_q  <= s3_vlow_d;
      s3_lt_q    <= s3_lt_d;
      s3_vlt_q   <= s3_vlt_d;
      s3_temp1_q <= s2_temp1_q;
      s3_t2_q    <= s2_t2_q;
      s3_off1_q  <= s2_off1_q;
      s3_sens1_q <= s2_sens1_q;
    end
    if (en_i[4]) begin
      s4_off2a_q  <= s4_off2a_d;
      s4_off2b_q  <= s4_off2b_d;
      s4_sens2a_q <= s4_sens2a_d;
      s4_sens2b_q <= s4_sens2b_d;
      temp_q[4]   <= s4_temp_d;
      s4_off1_q   <= s3_off1_q;
      s4_sens1_q  <= s3_sens1_q;
    end
    if (en_i[5]) begin
      s5_off_q  <= s5_off_d;
      s5_sens_q <= s5_sens_d;
    end
    if (en_i[6]) begin
      s6_plo_q <= s6_plo_d;
      s6_phi_q <= s6_phi_d;
      s6_off_q <= s5_off_q;
    end
    if (en_i[7]) begin
      s7_prod_q <= s7_prod_d;
      s7_off_q  <= s6_off_q;
    end
    if (en_i[8]) begin
      s8_q1_q  <= s8_q1_d;
      s8_off_q <= s7_off_q;
    end
    if (en_i[9]) begin
      s9_diff_q <= s9_diff_d;
    end
    if (en_i[10]) begin
      valid_res_o           <= res_ok;
      temperature_centi_c_o <= res_ok ? temp_q[9][14:0] : 15'sd0;
      pressure_pa_o         <= res_ok ? pres[17:0] : 18'd0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/baro_sensor_compensation.sv -----
// Top level of the barometric sensor compensation block.
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o      | raw_pressure_i, raw_temperature_i
//  out     | output    | out_valid_o / out_stall_i    | valid_res_o, temperature_centi_c_o,
//          |           |                              | pressure_pa_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_stall_i is low; a taken word passes through every stage to the outputs.
// Depth is set by the 24 x 40 bit pressure product, split into two partial products.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up
// and a stalled output holds while earlier stages keep filling.
// Reset clears the stage valid bits and loads the calibration registers' reset values.
// cfg_ready_o is always high; a write to an unused index is dropped.
`default_nettype none

module baro_sensor_compensation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [23:0]                       raw_pressure_i,
  input  logic [23:0]                       raw_temperature_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              valid_res_o,
  output logic signed [14:0]                temperature_centi_c_o,
  output logic [17:0]                       pressure_pa_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned NS = bsc_pkg::NUM_STAGES;

  bsc_pkg::cfg_t cfg_d, cfg_q;
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsc_pkg::REG_SENS_COEFF:       cfg_d.c1    = cfg_data_i[15:0];
        bsc_pkg::REG_OFFSET_COEFF:     cfg_d.c2    = cfg_data_i[15:0];
        bsc_pkg::REG_SENS_TEMPCO:      cfg_d.c3    = cfg_data_i[15:0];
        bsc_pkg::REG_OFFSET_TEMPCO:    cfg_d.c4    = cfg_data_i[15:0];
        bsc_pkg::REG_REF_TEMP_COEFF:   cfg_d.c5    = cfg_data_i[15:0];
        bsc_pkg::REG_TEMP_SLOPE_COEFF: cfg_d.c6    = cfg_data_i[15:0];
        bsc_pkg::REG_MIN_PRESSURE:     cfg_d.p_min = cfg_data_i;
        bsc_pkg::REG_MAX_PRESSURE:     cfg_d.p_max = cfg_data_i;
        default:                       cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c1    <= 16'd0;
      cfg_q.c2    <= 16'd0;
      cfg_q.c3    <= 16'd0;
      cfg_q.c4    <= 16'd0;
      cfg_q.c5    <= 16'd0;
      cfg_q.c6    <= 16'd0;
      cfg_q.p_min <= bsc_pkg::P_MIN_RESET;
      cfg_q.p_max <= bsc_pkg::P_MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // stage k loads when it is empty or its contents move on
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NS-1];

  bsc_datapath u_datapath (
    .clk_i                 (clk_i),
    .en_i                  (en),
    .cfg_i                 (cfg_q),
    .raw_pressure_i        (raw_pressure_i),
    .raw_temperature_i     (raw_temperature_i),
    .valid_res_o           (valid_res_o),
    .temperature_centi_c_o (temperature_centi_c_o),
    .pressure_pa_o         (pressure_pa_o)
  );

`ifndef SYNTHESIS
  a_temp_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      ((temperature_centi_c_o >= bsc_pkg::TEMP_MIN) &&
       (temperature_centi_c_o <= bsc_pkg::TEMP_MAX)))
    else $error("valid result with temperature outside window");

  a_invalid_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      ((temperature_centi_c_o == 15'sd0) && (pressure_pa_o == 18'd0)))
    else $error("invalid result carries nonzero fields");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word did not enter the first stage");
`endif

endmodule

`default_nettype wire

// ----- bench/bsc_reading_checker.sv -----
// Checker that predicts and compares every compensated reading of the block.
`timescale 1ns / 100ps

module bsc_reading_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [23:0]                    raw_pressure_i,
  input  logic [23:0]                    raw_temperature_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           valid_res_i,
  input  logic signed [14:0]             temperature_centi_c_i,
  input  logic [17:0]                    pressure_pa_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             in_range_o
);

  localparam longint T2_DIV = 64'sd2147483648;

  typedef struct packed {
    logic        ok;
    logic [14:0] temp;
    logic [17:0] press;
  } reading_t;

  bsc_pkg::cfg_t cal;
  reading_t      readings[$];
  reading_t      want;
  int            errors;
  int            checked;
  int            in_range;

  function automatic reading_t compensate(input logic [23:0] raw_p, input logic [23:0] raw_t,
                                          input bsc_pkg::cfg_t k);
    longint   d1, d2, c1, c2, c3, c4, c5, c6, pmin, pmax;
    longint   dt, temp_c, off, sens, p, dev, sq, dv, vsq, off2, sens2;
    reading_t r;
    r    = '0;
    d1   = longint'(raw_p);
    d2   = longint'(raw_t);
    c1   = longint'(k.c1);
    c2   = longint'(k.c2);
    c3   = longint'(k.c3);
    c4   = longint'(k.c4);
    c5   = longint'(k.c5);
    c6   = longint'(k.c6);
    pmin = longint'(k.p_min);
    pmax = longint'(k.p_max);
    if (d1 == 0 || d2 == 0) return r;

    dt     = d2 - c5 * 256;
    temp_c = 2000 + dt * c6 / 8388608;
    off    = c2 * 131072 + c4 * dt / 64;
    sens   = c1 * 65536 + c3 * dt / 128;

    // second-order terms below 20 C, an extra one below -15 C
    if (temp_c < 2000) begin
      dev   = temp_c - 2000;
      sq    = dev * dev;
      off2  = 61 * sq / 16;
      sens2 = 2 * sq;
      if (temp_c < -1500) begin
        dv    = temp_c + 1500;
        vsq   = dv * dv;
        off2  += 15 * vsq;
        sens2 += 8 * vsq;
      end
      temp_c -= dt * dt / T2_DIV;
      off    -= off2;
      sens   -= sens2;
    end

    p = (d1 * sens / 2097152 - off) / 32768;
    if (temp_c < bsc_pkg::TEMP_MIN || temp_c > bsc_pkg::TEMP_MAX || p < pmin || p > pmax)
      return r;

    r.ok    = 1'b1;
    r.temp  = temp_c[14:0];
    r.press = p[17:0];
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint exp_v, input longint got_v);
    errors++;
    $error("%s: expected %0d, got %0d", field, exp_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal       = '0;
      cal.p_min = bsc_pkg::P_MIN_RESET;
      cal.p_max = bsc_pkg::P_MAX_RESET;
      readings.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (readings.size() == 0) begin
          errors++;
          $error("result word with no reading pending");
        end else begin
          want = readings.pop_front();
          checked++;
          if (want.ok) in_range++;
          if (valid_res_i !== want.ok)
            note_mismatch("valid_res", longint'(want.ok), longint'(valid_res_i));
          if (temperature_centi_c_i !== want.temp)
            note_mismatch("temperature_centi_c", longint'($signed(want.temp)),
                          longint'(temperature_centi_c_i));
          if (pressure_pa_i !== want.press)
            note_mismatch("pressure_pa", longint'(want.press), longint'(pressure_pa_i));
        end
      end

      if (in_valid_i && !in_stall_i)
        readings.push_back(compensate(raw_pressure_i, raw_temperature_i, cal));

      // the 16-bit coefficients keep only the low bits of the data word
      if (cfg_valid_i && cfg_ready_i) begin
        case (bsc_pkg::reg_idx_e'(cfg_index_i))
          bsc_pkg::REG_SENS_COEFF:       cal.c1    = cfg_data_i[15:0];
          bsc_pkg::REG_OFFSET_COEFF:     cal.c2    = cfg_data_i[15:0];
          bsc_pkg::REG_SENS_TEMPCO:      cal.c3    = cfg_data_i[15:0];
          bsc_pkg::REG_OFFSET_TEMPCO:    cal.c4    = cfg_data_i[15:0];
          bsc_pkg::REG_REF_TEMP_COEFF:   cal.c5    = cfg_data_i[15:0];
          bsc_pkg::REG_TEMP_SLOPE_COEFF: cal.c6    = cfg_data_i[15:0];
          bsc_pkg::REG_MIN_PRESSURE:     cal.p_min = cfg_data_i[17:0];
          bsc_pkg::REG_MAX_PRESSURE:     cal.p_max = cfg_data_i[17:0];
          default: ;
        endcase
      end
    end
    errors_o   <= errors;
    pending_o  <= readings.size();
    checked_o  <= checked;
    in_range_o <= in_range;
  end

endmodule

// ----- bench/tb.sv -----
// Stimulus and verdict for the barometric sensor compensation block.
`timescale 1ns / 100ps

module tb;

  localparam int     SPARE_IDX_LO = int'(bsc_pkg::REG_MAX_PRESSURE) + 1;
  localparam int     SPARE_IDX_HI = (1 << bsc_pkg::CFG_IDX_W) - 1;
  localparam int     NUM_PHASES   = 6;
  localparam int     SETTLE_LIMIT = 5000;
  localparam longint RAW_MAX      = 16777215;
  localparam longint TIMEOUT_NS   = 1000000;

  localparam bsc_pkg::cfg_t DATASHEET_CAL = '{c1: 16'd46372, c2: 16'd43981, c3: 16'd29059,
                                              c4: 16'd27842, c5: 16'd31553, c6: 16'd28165,
                                              p_min: bsc_pkg::P_MIN_RESET,
                                              p_max: bsc_pkg::P_MAX_RESET};

  logic                           clk;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic [23:0]                    raw_pressure    = '0;
  logic [23:0]                    raw_temperature = '0;
  logic                           out_stall       = 1'b0;
  logic                           cfg_valid       = 1'b0;
  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic                  valid_res;
  logic signed [14:0]    temperature_centi_c;
  logic [17:0]           pressure_pa;
  logic                  cfg_ready;

  int            errors, pending, checked, in_range;
  bsc_pkg::cfg_t cal_now;
  int            cal_sets;
  bit            calm;

  baro_sensor_compensation dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .raw_pressure_i        (raw_pressure),
    .raw_temperature_i     (raw_temperature),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .valid_res_o           (valid_res),
    .temperature_centi_c_o (temperature_centi_c),
    .pressure_pa_o         (pressure_pa),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  bsc_reading_checker readings_chk (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .raw_pressure_i        (raw_pressure),
    .raw_temperature_i     (raw_temperature),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .valid_res_i           (valid_res),
    .temperature_centi_c_i (temperature_centi_c),
    .pressure_pa_i         (pressure_pa),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_i           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .errors_o              (errors),
    .pending_o             (pending),
    .checked_o             (checked),
    .in_range_o            (in_range)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [23:0] clamp_raw(input longint v);
    if (v < 1) return 24'd1;
    if (v > RAW_MAX) return 24'hFFFFFF;
    return v[23:0];
  endfunction

  // first-order inversion of the temperature formula
  function automatic logic [23:0] raw_temp_for(input bsc_pkg::cfg_t k, input int centi);
    longint c5, c6, dt;
    c5 = longint'(k.c5);
    c6 = longint'(k.c6);
    if (c6 == 0) return 24'($urandom);
    dt = longint'(centi - 2000) * 8388608 / c6;
    return clamp_raw(c5 * 256 + dt);
  endfunction

  // first-order inversion of the pressure formula at a given raw temperature
  function automatic logic [23:0] raw_press_for(input bsc_pkg::cfg_t k, input int pa,
                                                input logic [23:0] raw_t);
    longint c1, c2, c3, c4, c5, d2, dt, off, sens;
    c1   = longint'(k.c1);
    c2   = longint'(k.c2);
    c3   = longint'(k.c3);
    c4   = longint'(k.c4);
    c5   = longint'(k.c5);
    d2   = longint'(raw_t);
    dt   = d2 - c5 * 256;
    off  = c2 * 131072 + c4 * dt / 64;
    sens = c1 * 65536 + c3 * dt / 128;
    if (sens <= 0) return 24'($urandom);
    return clamp_raw((longint'(pa) * 32768 + off) * 2097152 / sens);
  endfunction

  function automatic bsc_pkg::cfg_t random_cal(input int unsigned lo);
    bsc_pkg::cfg_t k;
    k.c1    = 16'($urandom_range(lo, 65535));
    k.c2    = 16'($urandom_range(lo, 65535));
    k.c3    = 16'($urandom_range(lo, 65535));
    k.c4    = 16'($urandom_range(lo, 65535));
    k.c5    = 16'($urandom_range(lo, 65535));
    k.c6    = 16'($urandom_range(lo, 65535));
    k.p_min = bsc_pkg::P_MIN_RESET;
    k.p_max = bsc_pkg::P_MAX_RESET;
    return k;
  endfunction

  function automatic logic [bsc_pkg::CFG_DATA_W-1:0] coeff_word(input logic [15:0] c,
                                                                input bit spill);
    logic [bsc_pkg::CFG_DATA_W-1:0] w;
    w = (bsc_pkg::CFG_DATA_W)'(c);
    if (spill) w[bsc_pkg::CFG_DATA_W-1:16] = (bsc_pkg::CFG_DATA_W-16)'($urandom_range(1, 3));
    return w;
  endfunction

  function automatic logic [23:0] corner_raw();
    case ($urandom_range(0, 3))
      0:       return 24'd0;
      1:       return 24'd1;
      2:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic push_pair(input logic [23:0] rp, input logic [23:0] rt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    raw_pressure    <= rp;
    raw_temperature <= rt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_aimed(input int centi, input int pa);
    logic [23:0] rt;
    rt = raw_temp_for(cal_now, centi);
    push_pair(raw_press_for(cal_now, pa, rt), rt);
  endtask

  task automatic push_random_pair();
    int unsigned pick;
    int          lo, hi;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      lo = int'(cal_now.p_min < cal_now.p_max ? cal_now.p_min : cal_now.p_max) - 3000;
      hi = int'(cal_now.p_min < cal_now.p_max ? cal_now.p_max : cal_now.p_min) + 3000;
      if (lo < 0) lo = 0;
      push_aimed(int'($urandom_range(0, 13500)) - 4500, int'($urandom_range(lo, hi)));
    end else if (pick < 92) begin
      push_pair(24'($urandom), 24'($urandom));
    end else begin
      push_pair(corner_raw(), corner_raw());
    end
  endtask

  task automatic write_reg(input logic [bsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_calibration(input bsc_pkg::cfg_t k, input bit spill);
    write_reg(bsc_pkg::REG_SENS_COEFF,       coeff_word(k.c1, spill));
    write_reg(bsc_pkg::REG_OFFSET_COEFF,     coeff_word(k.c2, spill));
    write_reg(bsc_pkg::REG_SENS_TEMPCO,      coeff_word(k.c3, spill));
    write_reg(bsc_pkg::REG_OFFSET_TEMPCO,    coeff_word(k.c4, spill));
    write_reg(bsc_pkg::REG_REF_TEMP_COEFF,   coeff_word(k.c5, spill));
    write_reg(bsc_pkg::REG_TEMP_SLOPE_COEFF, coeff_word(k.c6, spill));
    write_reg(bsc_pkg::REG_MIN_PRESSURE,     k.p_min);
    write_reg(bsc_pkg::REG_MAX_PRESSURE,     k.p_max);
    // unused index, must be dropped
    write_reg((bsc_pkg::CFG_IDX_W)'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)),
              (bsc_pkg::CFG_DATA_W)'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    cal_now = k;
    cal_sets++;
  endtask

  task automatic settle();
    int w;
    @(negedge clk);
    in_valid <= 1'b0;
    for (w = 0; w < SETTLE_LIMIT && pending != 0; w++) @(posedge clk);
    repeat (bsc_pkg::NUM_STAGES + 2) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
  end

  initial begin
    bsc_pkg::cfg_t k;
    int            n;
    bit            spill;

    cal_now       = '0;
    cal_now.p_min = bsc_pkg::P_MIN_RESET;
    cal_now.p_max = bsc_pkg::P_MAX_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset calibration: all coefficients zero, nothing lands in the window
    push_pair(24'd6465444, 24'd8077636);
    push_pair(24'hFFFFFF, 24'hFFFFFF);
    push_pair(24'd1, 24'd1);
    settle();

    load_calibration(DATASHEET_CAL, 1'b0);
    push_pair(24'd6465444, 24'd8077636);
    push_pair(24'd0, 24'd8077636);
    push_pair(24'd6465444, 24'd0);
    push_pair(24'd0, 24'd0);
    push_pair(24'hFFFFFF, 24'hFFFFFF);
    push_pair(24'd1, 24'd1);
    push_pair(24'hAAAAAA, 24'h555555);
    push_pair(24'h555555, 24'hAAAAAA);
    push_aimed(1990, 100000);   // just under 20 C
    push_aimed(-1400, 95000);
    push_aimed(-1600, 90000);   // very-low term kicks in
    push_aimed(-3900, 80000);
    push_aimed(-4600, 80000);   // too cold
    push_aimed(8400, 110000);
    push_aimed(8700, 100000);   // too hot
    push_aimed(2000, 800);      // under the window
    push_aimed(2500, 125000);   // over the window
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      k     = DATASHEET_CAL;
      spill = 1'b0;
      n     = 120;
      case (ph)
        1: begin
          k       = random_cal(20000);
          k.p_min = '0;
          k.p_max = '1;
        end
        2: begin
          k       = random_cal(65535);
          spill   = 1'b1;
          k.p_min = 18'($urandom_range(0, 60000));
          k.p_max = 18'($urandom_range(100000, 262143));
          n       = 100;
        end
        3: begin
          // inverted window: no word may come out valid
          k       = random_cal(0);
          k.p_min = 18'($urandom_range(131072, 262143));
          k.p_max = 18'($urandom_range(0, 131071));
          n       = 60;
        end
        4: begin
          k       = random_cal(20000);
          k.p_min = 18'($urandom_range(0, 80000));
          k.p_max = 18'($urandom_range(80000, 262143));
          n       = 150;
        end
        5: begin
          k    = random_cal(20000);
          calm = 1'b1;
          n    = 150;
        end
        default: ;
      endcase
      load_calibration(k, spill);
      repeat (n) push_random_pair();
      settle();
    end

    if (pending != 0) $error("%0d readings never came out", pending);
    $display("%0d readings checked, %0d in range, over %0d calibration sets",
             checked, in_range, cal_sets);
    $display("covered zero and full-scale conversions, both cold corrections, window edges");
    if (errors == 0 && pending == 0) begin
      $display("baro_sensor_compensation regression: pass");
    end else begin
      $display("baro_sensor_compensation regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $error("timed out");
    $display("baro_sensor_compensation regression: fail");
    $finish;
  end

endmodule
